[rtl/cvg_pkg.sv]
// cvg_pkg: shared types, constants and the quarter-wave sine table builder
// for the cone vertex generator. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cvg_pkg;

  // Quarter-wave table resolution, a power of two.
  localparam int ANGLE_TABLE_DEPTH = 1024;
  localparam int ANG_AW  = $clog2(ANGLE_TABLE_DEPTH);   // index within a quadrant
  localparam int TAB_AW  = ANG_AW + 1;                  // 0..DEPTH inclusive
  localparam int FULL_W  = ANG_AW + 2;                  // phase over a full turn
  localparam int SINE_W  = 15;                          // 0..16384

  localparam int ONE_Q14 = 16384;
  localparam int ONE_Q16 = 65536;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Pipelined divider geometry: one quotient bit per stage.
  localparam int DIV_NUM_W = 46;
  localparam int DIV_DEN_W = 32;
  localparam int DIV_Q_W   = 17;
  localparam int DIV_LAT   = DIV_Q_W;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    SEC_SIDE       = 3'd0,
    SEC_TOP_CENTER = 3'd1,
    SEC_TOP_RIM    = 3'd2,
    SEC_BOT_CENTER = 3'd3,
    SEC_BOT_RIM    = 3'd4
  } section_t;

  typedef enum logic [2:0] {
    REG_TOP_RADIUS    = 3'd0,
    REG_BOTTOM_RADIUS = 3'd1,
    REG_CONE_LENGTH   = 3'd2,
    REG_RING_COUNT    = 3'd3,
    REG_SLICE_COUNT   = 3'd4
  } reg_index_t;

  // Configuration as seen by the datapath, with the derived normal length.
  typedef struct packed {
    logic [15:0] top_radius;
    logic [15:0] bottom_radius;
    logic [15:0] cone_length;
    logic [7:0]  ring_count;
    logic [7:0]  slice_count;
    logic [31:0] norm_len;      // floor(sqrt((L*L + D*D) << 28))
    logic        busy;          // norm_len being recomputed
  } cfg_t;

  // Classified request item.
  typedef struct packed {
    section_t   sec;
    logic [7:0] ring;
    logic [7:0] slice;
    logic       bad;
  } req_t;

  // Sine table, Q1.14, entry i = sin(i/DEPTH * pi/2), 13-term Taylor series in Q30.
  function automatic logic [ANGLE_TABLE_DEPTH:0][SINE_W-1:0] build_sine();
    logic [ANGLE_TABLE_DEPTH:0][SINE_W-1:0] tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint sum;
    longint v;
    for (int i = 0; i <= ANGLE_TABLE_DEPTH; i++) begin
      x    = (HALF_PI_Q30 * 64'(i) + 64'(ANGLE_TABLE_DEPTH / 2)) / 64'(ANGLE_TABLE_DEPTH);
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int k = 1; k <= 12; k++) begin
        term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) sum = sum - longint'(term);
        else            sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      v = (sum + 32768) >>> 16;
      if (v > ONE_Q14) v = ONE_Q14;
      tab[i] = SINE_W'(v);
    end
    return tab;
  endfunction

endpackage

`default_nettype wire

[rtl/cvg_req_if.sv]
// cvg_req_if: request channel (section, ring, slice) with valid/ready.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface cvg_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] section;
  logic [7:0] ring;
  logic [7:0] slice;

  modport source (output valid, section, ring, slice, input ready);
  modport sink   (input valid, section, ring, slice, output ready);
endinterface

`default_nettype wire

[rtl/cvg_vtx_if.sv]
// cvg_vtx_if: vertex result channel with valid/ready.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface cvg_vtx_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] pos_x;
  logic signed [16:0] pos_y;
  logic signed [16:0] pos_z;
  logic        [16:0] tex_u;
  logic        [16:0] tex_v;
  logic signed [15:0] norm_x;
  logic signed [15:0] norm_y;
  logic signed [15:0] norm_z;
  logic               bad_request;

  modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v,
                  norm_x, norm_y, norm_z, bad_request, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, tex_u, tex_v,
                  norm_x, norm_y, norm_z, bad_request, output ready);
endinterface

`default_nettype wire

[rtl/cone_vertex_generator.sv]
// cone_vertex_generator: top level of the truncated cone vertex generator.
// Depends on cvg_pkg, cvg_req_if, cvg_vtx_if, cvg_cfg, cvg_front, cvg_queue,
// cvg_back.
//
// Usage:
//  - req channel (valid/ready): section, ring, slice. One item in, one
//    vertex item out, in request order.
//  - vtx channel (valid/ready): position Q8.8, uv Q1.16, normal Q1.14 and
//    bad_request.
//  - Config port: write_enable/write_index/write_data, registers indexed in
//    the order top_radius, bottom_radius, cone_length, ring_count,
//    slice_count; other indexes are ignored. Write only while idle.
//  - Throughput: one item per cycle sustained while vtx.ready is high and
//    no normal length root is being computed. Each item passes through the
//    two 17-stage divider pipelines (angle/interpolation, then normal).
//  - After reset and after every config write, req.ready stays low while
//    the normal length root is computed, one bit pair a cycle.
//  - When vtx.ready is low the whole back pipeline holds; the 4-entry queue
//    and the front register keep taking items until full.
`timescale 1ns / 1ps
`default_nettype none

module cone_vertex_generator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        write_enable,
  input  wire logic [2:0]  write_index,
  input  wire logic [15:0] write_data,
  cvg_req_if.sink          req,
  cvg_vtx_if.source        vtx
);
  import cvg_pkg::*;

  cfg_t cfg;
  req_t f_item;
  logic f_valid;
  logic f_ready;
  req_t q_head;
  logic q_valid;
  logic q_pop;

  // configuration and normal length root
  cvg_cfg u_cfg (
    .clk, .rst, .write_enable, .write_index, .write_data, .cfg
  );

  // front: accept and classify
  cvg_front u_front (
    .clk, .rst, .cfg, .req,
    .item(f_item), .item_valid(f_valid), .item_ready(f_ready)
  );

  // decoupling queue
  cvg_queue u_queue (
    .clk, .rst,
    .push_data(f_item), .push_valid(f_valid), .push_ready(f_ready),
    .head(q_head), .head_valid(q_valid), .pop(q_pop)
  );

  // back: vertex datapath and output register
  cvg_back u_back (
    .clk, .rst, .cfg,
    .head(q_head), .head_valid(q_valid), .pop(q_pop), .vtx
  );

endmodule

`default_nettype wire

[rtl/cvg_cfg.sv]
// cvg_cfg: configuration registers and the iterative square root of the
// side normal length. Depends on cvg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cvg_cfg (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        write_enable,
  input  wire logic [2:0]  write_index,
  input  wire logic [15:0] write_data,
  output cvg_pkg::cfg_t    cfg
);
  import cvg_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_SQUARE, ST_LOAD, ST_ROOT} state_t;

  state_t      state;
  logic [15:0] top_radius;
  logic [15:0] bottom_radius;
  logic [15:0] cone_length;
  logic [7:0]  ring_count;
  logic [7:0]  slice_count;
  logic [31:0] norm_len;
  logic [31:0] sq_len;
  logic [31:0] sq_diff;
  logic [63:0] rad;
  logic [63:0] root;
  logic [63:0] bitv;

  logic [16:0] diff;
  logic [15:0] diff_mag;
  logic [63:0] trial;
  logic        take;
  logic [63:0] root_next;
  logic [32:0] sq_sum;

  assign diff      = {1'b0, bottom_radius} - {1'b0, top_radius};
  assign diff_mag  = diff[16] ? 16'(17'd0 - diff) : diff[15:0];
  assign trial     = root + bitv;
  assign take      = rad >= trial;
  assign root_next = take ? ((root >> 1) + bitv) : (root >> 1);
  assign sq_sum    = {1'b0, sq_len} + {1'b0, sq_diff};

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_SQUARE;
      top_radius    <= 16'd0;
      bottom_radius <= 16'd256;
      cone_length   <= 16'd256;
      ring_count    <= 8'd16;
      slice_count   <= 8'd16;
    end else if (write_enable) begin
      // any write restarts the root, even one to an unused index
      state <= ST_SQUARE;
      unique case (write_index)
        REG_TOP_RADIUS:    top_radius    <= write_data;
        REG_BOTTOM_RADIUS: bottom_radius <= write_data;
        REG_CONE_LENGTH:   cone_length   <= write_data;
        REG_RING_COUNT:    ring_count    <= write_data[7:0];
        REG_SLICE_COUNT:   slice_count   <= write_data[7:0];
        default: ;
      endcase
    end else begin
      unique case (state)
        ST_SQUARE: begin
          sq_len  <= 32'(cone_length) * 32'(cone_length);
          sq_diff <= 32'(diff_mag) * 32'(diff_mag);
          state   <= ST_LOAD;
        end
        ST_LOAD: begin
          rad   <= 64'(sq_sum) << 28;
          root  <= 64'd0;
          bitv  <= 64'd1 << 62;
          state <= ST_ROOT;
        end
        ST_ROOT: begin
          if (take) rad <= rad - trial;
          root <= root_next;
          bitv <= bitv >> 2;
          if (bitv[0]) begin
            norm_len <= root_next[31:0];
            state    <= ST_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

  assign cfg.top_radius    = top_radius;
  assign cfg.bottom_radius = bottom_radius;
  assign cfg.cone_length   = cone_length;
  assign cfg.ring_count    = ring_count;
  assign cfg.slice_count   = slice_count;
  assign cfg.norm_len      = norm_len;
  assign cfg.busy          = (state != ST_IDLE);

endmodule

`default_nettype wire

[rtl/cvg_front.sv]
// cvg_front: accepts requests and classifies them (section, range check).
// Depends on cvg_pkg and cvg_req_if.
`timescale 1ns / 1ps
`default_nettype none

module cvg_front (
  input  wire logic    clk,
  input  wire logic    rst,
  input  cvg_pkg::cfg_t cfg,
  cvg_req_if.sink      req,
  output cvg_pkg::req_t item,
  output logic         item_valid,
  input  wire logic    item_ready
);
  import cvg_pkg::*;

  logic take;
  logic slice_bad;
  logic ring_bad;
  logic bad;

  assign req.ready = !cfg.busy && (!item_valid || item_ready);
  assign take      = req.valid && req.ready;

  assign slice_bad = (cfg.slice_count == 8'd0) || (req.slice > cfg.slice_count);
  assign ring_bad  = (cfg.ring_count < 8'd2) || (req.ring >= cfg.ring_count);

  always_comb begin
    unique case (req.section)
      SEC_SIDE:                       bad = slice_bad || ring_bad;
      SEC_TOP_RIM, SEC_BOT_RIM:       bad = slice_bad;
      SEC_TOP_CENTER, SEC_BOT_CENTER: bad = 1'b0;
      default:                        bad = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (take) begin
      item_valid <= 1'b1;
    end else if (item_ready) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item.sec   <= section_t'(req.section);
      item.ring  <= req.ring;
      item.slice <= req.slice;
      item.bad   <= bad;
    end
  end

endmodule

`default_nettype wire

[rtl/cvg_queue.sv]
// cvg_queue: short FIFO of classified items between front and back.
// Depends on cvg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cvg_queue (
  input  wire logic     clk,
  input  wire logic     rst,
  input  cvg_pkg::req_t push_data,
  input  wire logic     push_valid,
  output logic          push_ready,
  output cvg_pkg::req_t head,
  output logic          head_valid,
  input  wire logic     pop
);
  import cvg_pkg::*;

  req_t                mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;
  logic                push;
  logic                pull;

  assign push_ready = (count != (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pull       = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pull) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pull)      count <= count + 1'b1;
      else if (pull && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

endmodule

`default_nettype wire

[rtl/cvg_div.sv]
// cvg_div: pipelined restoring divider, one quotient bit per stage.
// Depends on cvg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cvg_div (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [cvg_pkg::DIV_NUM_W-1:0] num,
  input  wire logic [cvg_pkg::DIV_DEN_W-1:0] den,
  output logic      [cvg_pkg::DIV_Q_W-1:0]   quot
);
  import cvg_pkg::*;

  localparam int CMP_W = DIV_DEN_W + DIV_Q_W;

  logic [DIV_NUM_W-1:0] rem_q [DIV_Q_W];
  logic [DIV_DEN_W-1:0] den_q [DIV_Q_W];
  logic [DIV_Q_W-1:0]   quo_q [DIV_Q_W];

  for (genvar s = 0; s < DIV_Q_W; s++) begin : g_stage
    localparam int K = DIV_Q_W - 1 - s;
    logic [DIV_NUM_W-1:0] rem_in;
    logic [DIV_DEN_W-1:0] den_in;
    logic [DIV_Q_W-1:0]   quo_in;
    logic [CMP_W-1:0]     trial;
    logic                 fits;

    if (s == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    assign trial = CMP_W'(den_in) << K;
    assign fits  = CMP_W'(rem_in) >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[s] <= fits ? (rem_in - trial[DIV_NUM_W-1:0]) : rem_in;
        den_q[s] <= den_in;
        quo_q[s] <= quo_in | (fits ? (DIV_Q_W'(1) << K) : '0);
      end
    end
  end

  assign quot = quo_q[DIV_Q_W-1];

endmodule

`default_nettype wire

[rtl/cvg_back.sv]
// cvg_back: vertex datapath: angle/interpolation divides, sine lookup,
// products, normal divides and the output register. Depends on cvg_pkg,
// cvg_div and cvg_vtx_if.
`timescale 1ns / 1ps
`default_nettype none

module cvg_back (
  input  wire logic     clk,
  input  wire logic     rst,
  input  cvg_pkg::cfg_t cfg,
  input  cvg_pkg::req_t head,
  input  wire logic     head_valid,
  output logic          pop,
  cvg_vtx_if.source     vtx
);
  import cvg_pkg::*;

  localparam logic [ANGLE_TABLE_DEPTH:0][SINE_W-1:0] SINE_ROM = build_sine();

  typedef struct packed {
    section_t sec;
    logic     bad;
    logic     py_neg;
  } tag_t;

  typedef struct packed {
    tag_t        tag;
    logic [15:0] rad;
    logic [15:0] py_mag;
    logic [16:0] tu;
    logic [16:0] tv;
  } pass_t;

  typedef struct packed {
    pass_t       pass;
    logic [16:0] px;
    logic [16:0] pz;
    logic [15:0] c;
    logic [15:0] s;
    logic        c_neg;
    logic        s_neg;
  } late_t;

  logic adv;
  assign adv = !vtx.valid || vtx.ready;
  assign pop = adv && head_valid;

  // ---- numerators of the first divide group ----
  logic [7:0]  n8;
  logic [9:0]  pv;
  logic        py_neg;
  logic [9:0]  py_mag0;
  logic [25:0] py_prod;
  logic [7:0]  n_minus_r;
  logic [23:0] rad_b;
  logic [23:0] rad_t;
  logic [24:0] rad_sum;

  assign n8        = cfg.ring_count - 8'd1;
  assign pv        = {1'b0, head.ring, 1'b0} - {2'b00, n8};
  assign py_neg    = pv[9];
  assign py_mag0   = py_neg ? (10'd0 - pv) : pv;
  assign py_prod   = 26'(cfg.cone_length) * 26'(py_mag0);
  assign n_minus_r = n8 - head.ring;
  assign rad_b     = 24'(cfg.bottom_radius) * 24'(n_minus_r);
  assign rad_t     = 24'(cfg.top_radius) * 24'(head.ring);
  assign rad_sum   = 25'(rad_b) + 25'(rad_t) + 25'(n8 >> 1);

  logic                 v1;
  tag_t                 tag1;
  logic [DIV_NUM_W-1:0] ph_num, tv_num, tu_num, py_num, rad_num;
  logic [DIV_DEN_W-1:0] ph_den, tv_den, n_den, py_den;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= head_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tag1.sec    <= head.sec;
      tag1.bad    <= head.bad;
      tag1.py_neg <= py_neg;
      ph_num  <= DIV_NUM_W'({head.slice, (FULL_W+1)'(0)}) + DIV_NUM_W'(cfg.slice_count);
      ph_den  <= DIV_DEN_W'({cfg.slice_count, 1'b0});
      tv_num  <= DIV_NUM_W'({head.slice, 16'd0}) + DIV_NUM_W'(cfg.slice_count >> 1);
      tv_den  <= DIV_DEN_W'(cfg.slice_count);
      tu_num  <= DIV_NUM_W'({head.ring, 16'd0}) + DIV_NUM_W'(n8 >> 1);
      n_den   <= DIV_DEN_W'(n8);
      py_num  <= DIV_NUM_W'(py_prod) + DIV_NUM_W'(n8);
      py_den  <= DIV_DEN_W'({n8, 1'b0});
      rad_num <= DIV_NUM_W'(rad_sum);
    end
  end

  logic [DIV_Q_W-1:0] qa_ph, qa_tv, qa_tu, qa_py, qa_rad;

  cvg_div u_div_ph  (.clk, .en(adv), .num(ph_num),  .den(ph_den), .quot(qa_ph));
  cvg_div u_div_tv  (.clk, .en(adv), .num(tv_num),  .den(tv_den), .quot(qa_tv));
  cvg_div u_div_tu  (.clk, .en(adv), .num(tu_num),  .den(n_den),  .quot(qa_tu));
  cvg_div u_div_py  (.clk, .en(adv), .num(py_num),  .den(py_den), .quot(qa_py));
  cvg_div u_div_rad (.clk, .en(adv), .num(rad_num), .den(n_den),  .quot(qa_rad));

  logic va   [DIV_LAT];
  tag_t taga [DIV_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_LAT; i++) va[i] <= 1'b0;
    end else if (adv) begin
      va[0] <= v1;
      for (int i = 1; i < DIV_LAT; i++) va[i] <= va[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      taga[0] <= tag1;
      for (int i = 1; i < DIV_LAT; i++) taga[i] <= taga[i-1];
    end
  end

  // ---- sine / cosine lookup ----
  function automatic logic [TAB_AW-1:0] tab_addr(input logic [FULL_W-1:0] p);
    logic [TAB_AW-1:0] idx;
    idx = {1'b0, p[ANG_AW-1:0]};
    return p[ANG_AW] ? (TAB_AW'(ANGLE_TABLE_DEPTH) - idx) : idx;
  endfunction

  logic [FULL_W-1:0] ph_s;
  logic [FULL_W-1:0] ph_c;
  assign ph_s = qa_ph[FULL_W-1:0];
  assign ph_c = ph_s + FULL_W'(ANGLE_TABLE_DEPTH);

  logic              vr;
  pass_t             pass_r;
  logic [SINE_W-1:0] tab_s, tab_c;
  logic              s_neg_r, c_neg_r;

  always_ff @(posedge clk) begin
    if (rst) vr <= 1'b0;
    else if (adv) vr <= va[DIV_LAT-1];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pass_r.tag    <= taga[DIV_LAT-1];
      pass_r.rad    <= qa_rad[15:0];
      pass_r.py_mag <= qa_py[15:0];
      pass_r.tu     <= qa_tu;
      pass_r.tv     <= qa_tv;
      tab_s   <= SINE_ROM[tab_addr(ph_s)];
      tab_c   <= SINE_ROM[tab_addr(ph_c)];
      s_neg_r <= ph_s[FULL_W-1];
      c_neg_r <= ph_c[FULL_W-1];
    end
  end

  // ---- products ----
  logic [15:0] r_eff;
  always_comb begin
    unique case (pass_r.tag.sec)
      SEC_SIDE:    r_eff = pass_r.rad;
      SEC_TOP_RIM: r_eff = cfg.top_radius;
      SEC_BOT_RIM: r_eff = cfg.bottom_radius;
      default:     r_eff = 16'd0;
    endcase
  end

  logic        vm;
  pass_t       pass_m;
  logic [30:0] prod_rc, prod_rs, prod_lc, prod_ls;
  logic [15:0] c_m, s_m;
  logic        c_neg_m, s_neg_m;

  always_ff @(posedge clk) begin
    if (rst) vm <= 1'b0;
    else if (adv) vm <= vr;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pass_m  <= pass_r;
      prod_rc <= 31'(r_eff) * 31'(tab_c);
      prod_rs <= 31'(r_eff) * 31'(tab_s);
      prod_lc <= 31'(cfg.cone_length) * 31'(tab_c);
      prod_ls <= 31'(cfg.cone_length) * 31'(tab_s);
      c_m     <= c_neg_r ? (16'd0 - 16'(tab_c)) : 16'(tab_c);
      s_m     <= s_neg_r ? (16'd0 - 16'(tab_s)) : 16'(tab_s);
      c_neg_m <= c_neg_r;
      s_neg_m <= s_neg_r;
    end
  end

  // ---- numerators of the normal divides, position rounding ----
  logic [16:0] d_full;
  logic        d_neg;
  logic [15:0] d_mag;
  logic [31:0] rc_round, rs_round;
  logic [16:0] px_mag, pz_mag;

  assign d_full   = {1'b0, cfg.bottom_radius} - {1'b0, cfg.top_radius};
  assign d_neg    = d_full[16];
  assign d_mag    = d_neg ? 16'(17'd0 - d_full) : d_full[15:0];
  assign rc_round = {1'b0, prod_rc} + 32'd8192;
  assign rs_round = {1'b0, prod_rs} + 32'd8192;
  assign px_mag   = rc_round[30:14];
  assign pz_mag   = rs_round[30:14];

  logic                 vn;
  late_t                late_n;
  logic [DIV_NUM_W-1:0] nx_num, nz_num, ny_num;
  logic [DIV_DEN_W-1:0] nl_den;

  always_ff @(posedge clk) begin
    if (rst) vn <= 1'b0;
    else if (adv) vn <= vm;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      late_n.pass  <= pass_m;
      late_n.px    <= c_neg_m ? (17'd0 - px_mag) : px_mag;
      late_n.pz    <= s_neg_m ? (17'd0 - pz_mag) : pz_mag;
      late_n.c     <= c_m;
      late_n.s     <= s_m;
      late_n.c_neg <= c_neg_m;
      late_n.s_neg <= s_neg_m;
      nx_num <= DIV_NUM_W'({prod_lc, 14'd0}) + DIV_NUM_W'(cfg.norm_len[31:1]);
      nz_num <= DIV_NUM_W'({prod_ls, 14'd0}) + DIV_NUM_W'(cfg.norm_len[31:1]);
      ny_num <= DIV_NUM_W'({d_mag, 28'd0}) + DIV_NUM_W'(cfg.norm_len[31:1]);
      nl_den <= cfg.norm_len;
    end
  end

  logic [DIV_Q_W-1:0] qb_nx, qb_nz, qb_ny;

  cvg_div u_div_nx (.clk, .en(adv), .num(nx_num), .den(nl_den), .quot(qb_nx));
  cvg_div u_div_nz (.clk, .en(adv), .num(nz_num), .den(nl_den), .quot(qb_nz));
  cvg_div u_div_ny (.clk, .en(adv), .num(ny_num), .den(nl_den), .quot(qb_ny));

  logic  vb    [DIV_LAT];
  late_t lateb [DIV_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_LAT; i++) vb[i] <= 1'b0;
    end else if (adv) begin
      vb[0] <= vn;
      for (int i = 1; i < DIV_LAT; i++) vb[i] <= vb[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lateb[0] <= late_n;
      for (int i = 1; i < DIV_LAT; i++) lateb[i] <= lateb[i-1];
    end
  end

  // ---- result assembly ----
  function automatic logic [15:0] clamp_sign(input logic [DIV_Q_W-1:0] q, input logic neg);
    logic [15:0] m;
    m = (q > DIV_Q_W'(ONE_Q14)) ? 16'(ONE_Q14) : q[15:0];
    return neg ? (16'd0 - m) : m;
  endfunction

  late_t       lt;
  logic        no_len;
  logic [16:0] half_len;
  logic [16:0] py_side;
  logic [16:0] o_px, o_py, o_pz, o_tu, o_tv;
  logic [15:0] o_nx, o_ny, o_nz;

  assign lt       = lateb[DIV_LAT-1];
  assign no_len   = (cfg.norm_len == 32'd0);
  assign half_len = ({1'b0, cfg.cone_length} + 17'd1) >> 1;
  assign py_side  = lt.pass.tag.py_neg ? (17'd0 - 17'(lt.pass.py_mag)) : 17'(lt.pass.py_mag);

  always_comb begin
    o_px = '0; o_py = '0; o_pz = '0; o_tu = '0; o_tv = '0;
    o_nx = '0; o_ny = '0; o_nz = '0;
    if (!lt.pass.tag.bad) begin
      unique case (lt.pass.tag.sec)
        SEC_SIDE: begin
          o_px = lt.px;
          o_py = py_side;
          o_pz = lt.pz;
          o_tu = lt.pass.tu;
          o_tv = lt.pass.tv;
          if (no_len) begin
            // flat degenerate side: normal is just the radial direction
            o_nx = lt.c;
            o_nz = lt.s;
          end else begin
            o_nx = clamp_sign(qb_nx, lt.c_neg);
            o_ny = clamp_sign(qb_ny, d_neg);
            o_nz = clamp_sign(qb_nz, lt.s_neg);
          end
        end
        SEC_TOP_CENTER, SEC_TOP_RIM: begin
          o_py = half_len;
          o_tu = 17'(ONE_Q16);
          o_ny = 16'(ONE_Q14);
          if (lt.pass.tag.sec == SEC_TOP_RIM) begin
            o_px = lt.px;
            o_pz = lt.pz;
            o_tv = lt.pass.tv;
          end
        end
        SEC_BOT_CENTER, SEC_BOT_RIM: begin
          o_py = 17'd0 - half_len;
          o_tu = 17'(ONE_Q16);
          o_ny = 16'd0 - 16'(ONE_Q14);
          if (lt.pass.tag.sec == SEC_BOT_RIM) begin
            o_px = lt.px;
            o_pz = lt.pz;
            o_tv = lt.pass.tv;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vtx.valid <= 1'b0;
    else if (adv) vtx.valid <= vb[DIV_LAT-1];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vtx.pos_x       <= $signed(o_px);
      vtx.pos_y       <= $signed(o_py);
      vtx.pos_z       <= $signed(o_pz);
      vtx.tex_u       <= o_tu;
      vtx.tex_v       <= o_tv;
      vtx.norm_x      <= $signed(o_nx);
      vtx.norm_y      <= $signed(o_ny);
      vtx.norm_z      <= $signed(o_nz);
      vtx.bad_request <= lt.pass.tag.bad;
    end
  end

  a_no_pop_on_stall: assert property (@(posedge clk) disable iff (rst)
    vtx.valid && !vtx.ready |-> !pop)
    else $error("queue popped while result stalled");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    vtx.valid && vtx.bad_request |->
      vtx.pos_x == 0 && vtx.pos_y == 0 && vtx.pos_z == 0 && vtx.tex_u == 0 &&
      vtx.tex_v == 0 && vtx.norm_x == 0 && vtx.norm_y == 0 && vtx.norm_z == 0)
    else $error("bad request result carries nonzero fields");

  a_norm_range: assert property (@(posedge clk) disable iff (rst)
    vtx.valid |->
      vtx.norm_x <= 16'sd16384 && vtx.norm_x >= -16'sd16384 &&
      vtx.norm_y <= 16'sd16384 && vtx.norm_y >= -16'sd16384 &&
      vtx.norm_z <= 16'sd16384 && vtx.norm_z >= -16'sd16384)
    else $error("normal component out of range");

endmodule

`default_nettype wire
